// File: rtl/base64_stream_decoder_macros.svh
// Assertion macros shared by the base64 stream decoder checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define B64D_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("base64 decoder check failed");

// Consequent in the cycle after the antecedent.
`define B64D_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("base64 decoder check failed");

`endif

// File: rtl/b64d_pkg.sv
// Package for the base64 stream decoder: constants, the queue entry type
// and the character-to-sextet mapping. No dependencies.
`default_nettype none

package b64d_pkg;

  localparam int COUNT_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int              TOTAL_W   = 16;
  localparam logic [15:0]     TOTAL_MAX = 16'hFFFF;

  // Sextet codes; bit 6 set means the character is outside the alphabet.
  localparam logic [6:0] SEXTET_NONE  = 7'd64;
  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;

  localparam logic [7:0] LOWER_OFFSET = 8'd26;
  localparam logic [7:0] DIGIT_OFFSET = 8'd52;

  // One unit of work for the output side: one to three words.
  typedef struct packed {
    logic [23:0]        data;      // first word in the top byte
    logic [1:0]         count;     // number of words, 1..3
    logic               has_data;  // 0 for the empty end marker
    logic               last;      // final word closes the message
    logic [TOTAL_W-1:0] total;     // byte count, meaningful with last
  } entry_t;

  function automatic logic [6:0] map_char(input logic [7:0] c);
    logic [6:0] s;
    s = SEXTET_NONE;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      s = {1'b0, 6'(c - CHAR_UPPER_A)};
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      s = {1'b0, 6'(c - CHAR_LOWER_A + LOWER_OFFSET)};
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      s = {1'b0, 6'(c - CHAR_ZERO + DIGIT_OFFSET)};
    end else if (c == CHAR_PLUS) begin
      s = {1'b0, SEXTET_PLUS};
    end else if (c == CHAR_SLASH) begin
      s = {1'b0, SEXTET_SLASH};
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// File: rtl/b64d_front.sv
// Front end of the base64 decoder: classifies characters, gathers sextets
// and builds queue entries. Depends on b64d_pkg.
`default_nettype none

module b64d_front #(
  parameter int COUNT_BITS = b64d_pkg::COUNT_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      in_char,
  output logic                 push,
  output b64d_pkg::entry_t     entry
);

  localparam int SUM_W = COUNT_BITS + 1;
  localparam int EXT_W = (COUNT_BITS > b64d_pkg::TOTAL_W) ? COUNT_BITS : b64d_pkg::TOTAL_W;

  logic [17:0]           sextet_buf, sextet_buf_next;
  logic [1:0]            fill, fill_next;
  logic [COUNT_BITS-1:0] tally, tally_next;

  logic [6:0]            mapped;
  logic                  is_sym;
  logic [1:0]            add;
  logic [SUM_W-1:0]      tally_sum;
  logic [COUNT_BITS-1:0] tally_plus;
  logic [EXT_W-1:0]      tally_ext;
  logic [b64d_pkg::TOTAL_W-1:0] total_sat;

  assign mapped = b64d_pkg::map_char(in_char);
  assign is_sym = ~mapped[6];

  always_comb begin
    if (is_sym) begin
      add = (fill == 2'd3) ? 2'd3 : 2'd0;
    end else begin
      case (fill)
        2'd2:    add = 2'd1;
        2'd3:    add = 2'd2;
        default: add = 2'd0;
      endcase
    end
  end

  assign tally_sum  = {1'b0, tally} + SUM_W'(add);
  assign tally_plus = tally_sum[COUNT_BITS] ? '1 : tally_sum[COUNT_BITS-1:0];
  assign tally_ext  = EXT_W'(tally_plus);
  assign total_sat  = (tally_ext > EXT_W'(b64d_pkg::TOTAL_MAX)) ?
                      b64d_pkg::TOTAL_MAX : tally_ext[b64d_pkg::TOTAL_W-1:0];

  always_comb begin
    sextet_buf_next = sextet_buf;
    fill_next       = fill;
    tally_next      = tally;
    push            = 1'b0;
    entry           = '0;
    if (accept) begin
      if (is_sym) begin
        if (fill != 2'd3) begin
          sextet_buf_next = {sextet_buf[11:0], mapped[5:0]};
          fill_next       = fill + 2'd1;
        end else begin
          push            = 1'b1;
          entry.data      = {sextet_buf, mapped[5:0]};
          entry.count     = 2'd3;
          entry.has_data  = 1'b1;
          sextet_buf_next = '0;
          fill_next       = '0;
          tally_next      = tally_plus;
        end
      end else begin
        // A terminator flushes whatever whole bytes are pending.
        push        = 1'b1;
        entry.last  = 1'b1;
        entry.total = total_sat;
        case (fill)
          2'd2: begin
            entry.data     = {sextet_buf[11:4], 16'h0};
            entry.count    = 2'd1;
            entry.has_data = 1'b1;
          end
          2'd3: begin
            entry.data     = {sextet_buf[17:10], sextet_buf[9:2], 8'h0};
            entry.count    = 2'd2;
            entry.has_data = 1'b1;
          end
          default: begin
            entry.count    = 2'd1;
            entry.has_data = 1'b0;
          end
        endcase
        sextet_buf_next = '0;
        fill_next       = '0;
        tally_next      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sextet_buf <= '0;
      fill       <= '0;
      tally      <= '0;
    end else begin
      sextet_buf <= sextet_buf_next;
      fill       <= fill_next;
      tally      <= tally_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/b64d_queue.sv
// Short entry queue between the decoder front and back ends.
// Depends on b64d_pkg.
`default_nettype none

module b64d_queue #(
  parameter int DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire b64d_pkg::entry_t push_entry,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output b64d_pkg::entry_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64d_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/b64d_back.sv
// Back end of the base64 decoder: splits queue entries into output words
// held in a registered output stage. Depends on b64d_pkg.
`default_nettype none

module b64d_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             head_valid,
  input  wire b64d_pkg::entry_t head,
  output logic                  pop,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [23:0]           m_tdata,
  output logic                  m_tlast,
  output logic                  m_tuser
);

  logic [1:0] idx;
  logic       load;
  logic       last_word;
  logic [7:0] sel_byte;

  assign load      = ~m_tvalid | m_tready;
  assign last_word = (idx == head.count - 2'd1);
  assign pop       = load & head_valid & last_word;

  always_comb begin
    case (idx)
      2'd0:    sel_byte = head.data[23:16];
      2'd1:    sel_byte = head.data[15:8];
      default: sel_byte = head.data[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else if (load) begin
      m_tvalid <= head_valid;
      if (head_valid) begin
        idx <= last_word ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      m_tdata[7:0]  <= head.has_data ? sel_byte : 8'h0;
      m_tdata[23:8] <= (head.last && last_word) ? head.total : '0;
      m_tlast       <= head.last & last_word;
      m_tuser       <= head.has_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/base64_stream_decoder.sv
// Top level of the base64 stream decoder: front end, entry queue and
// back end. Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
//
// Usage. One base64 character enters per word on the slave channel
// (s_tdata[7:0]). Alphabet characters are gathered four at a time and each
// full group yields three decoded bytes on the master channel. Any other
// byte ('=', NUL, whitespace, anything at or above 128) ends the message:
// pending whole bytes are flushed, the final word carries tlast and the
// message byte count, and an empty word (tuser low) closes a message that
// has nothing left to flush.
// Each entry passes through the queue and then the registered output stage.
// The slave side takes one character per cycle while the queue has room;
// the back end sends one word per cycle while m_tready is high, so a
// steady run of full groups then sustains one character per cycle. The
// queue depth sets how long the input keeps flowing while the receiver
// stalls; after that s_tready drops until the back end drains an entry.
// Reset clears the partial group, the byte count, the queue and the
// output stage; the first character after reset starts a new message.
`default_nettype none

module base64_stream_decoder #(
  parameter int COUNT_BITS  = b64d_pkg::COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_char
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [7:0] out_byte, [23:8] total_bytes
  output logic             m_tlast,   // msg_last
  output logic             m_tuser    // byte_valid
);

  logic             accept;
  logic             push;
  logic             full;
  logic             pop;
  logic             head_valid;
  b64d_pkg::entry_t push_entry;
  b64d_pkg::entry_t head;

  assign s_tready = ~full;
  assign accept   = s_tvalid & s_tready;

  b64d_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_char (s_tdata),
    .push    (push),
    .entry   (push_entry)
  );

  b64d_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule

`default_nettype wire

// File: rtl/b64d_checker.sv
// Port-level checks for the base64 stream decoder, bound to its top level.
// Depends on base64_stream_decoder_macros.svh.
`default_nettype none
`include "base64_stream_decoder_macros.svh"

module b64d_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata,
  input wire logic        m_tlast,
  input wire logic        m_tuser
);

  // A stalled word stays put.
  `B64D_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
  // An empty word only ever closes a message.
  `B64D_ASSERT_SAME(a_empty_last, clk, rst, m_tvalid && !m_tuser, m_tlast)
  // An empty word carries a zero byte.
  `B64D_ASSERT_SAME(a_empty_zero, clk, rst, m_tvalid && !m_tuser, m_tdata[7:0] == 8'h0)
  // The byte count shows only on the closing word.
  `B64D_ASSERT_SAME(a_total_last, clk, rst, m_tvalid && !m_tlast, m_tdata[23:8] == 16'h0)

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// File: test/base64_stream_decoder_tb.sv
// Self-checking testbench for base64_stream_decoder: streams characters in, predicts the
// decoded words and compares every output word field by field.
// Depends on b64d_pkg and the base64_stream_decoder RTL.
`timescale 1ns / 100ps

module base64_stream_decoder_tb;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int GAP_MAX        = 14;
  localparam int TAIL_CYCLES    = 20;
  // Full groups in the long message.
  localparam int LONG_GROUPS    = 10;

  localparam logic [7:0] CHAR_PAD = 8'h3D;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  // One expected output word.
  typedef struct packed {
    logic [7:0]  data;
    logic        valid;
    logic        last;
    logic [15:0] total;
  } out_word_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] in_char
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // [7:0] out_byte, [23:8] total_bytes
  logic        m_tlast;   // msg_last
  logic        m_tuser;   // byte_valid

  out_word_t   pending_words[$];

  // Predictor state: pending sextets (oldest on top), their number, and
  // the saturating byte count of the current message.
  logic [17:0] held_sextets;
  logic [1:0]  held_count;
  logic [15:0] msg_bytes;

  bit          gaps_on;
  int unsigned mismatch_count;
  int unsigned idle_cycles;

  base64_stream_decoder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Character to sextet; bit 6 set marks a character outside the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] s;
    s = b64d_pkg::SEXTET_NONE;
    if (c inside {[b64d_pkg::CHAR_UPPER_A:b64d_pkg::CHAR_UPPER_Z]}) begin
      s = 7'(c - b64d_pkg::CHAR_UPPER_A);
    end else if (c inside {[b64d_pkg::CHAR_LOWER_A:b64d_pkg::CHAR_LOWER_Z]}) begin
      s = 7'(c - b64d_pkg::CHAR_LOWER_A) + 7'd26;
    end else if (c inside {[b64d_pkg::CHAR_ZERO:b64d_pkg::CHAR_NINE]}) begin
      s = 7'(c - b64d_pkg::CHAR_ZERO) + 7'd52;
    end else if (c == b64d_pkg::CHAR_PLUS) begin
      s = {1'b0, b64d_pkg::SEXTET_PLUS};
    end else if (c == b64d_pkg::CHAR_SLASH) begin
      s = {1'b0, b64d_pkg::SEXTET_SLASH};
    end
    return s;
  endfunction

  // Sextet to its alphabet character, used to build well-formed messages.
  function automatic logic [7:0] char_of_sextet(input logic [5:0] s);
    logic [7:0] c;
    if (s < 6'd26) begin
      c = b64d_pkg::CHAR_UPPER_A + 8'(s);
    end else if (s < 6'd52) begin
      c = b64d_pkg::CHAR_LOWER_A + 8'(s - 6'd26);
    end else if (s < 6'd62) begin
      c = b64d_pkg::CHAR_ZERO + 8'(s - 6'd52);
    end else if (s == b64d_pkg::SEXTET_PLUS) begin
      c = b64d_pkg::CHAR_PLUS;
    end else begin
      c = b64d_pkg::CHAR_SLASH;
    end
    return c;
  endfunction

  // Any byte that ends a message: padding, NUL, high bytes or other ASCII.
  function automatic logic [7:0] pick_terminator();
    logic [7:0] t;
    logic [6:0] s;
    case ($urandom_range(0, 3))
      0: t = CHAR_PAD;
      1: t = CHAR_NUL;
      2: t = 8'($urandom_range(128, 255));
      default: begin
        s = 7'd0;
        t = 8'd0;
        while (!s[6]) begin
          t = 8'($urandom_range(0, 127));
          s = sextet_of(t);
        end
      end
    endcase
    return t;
  endfunction

  function automatic logic [15:0] add_sat(input logic [15:0] a, input int unsigned n);
    logic [16:0] sum;
    sum = {1'b0, a} + 17'(n);
    return (sum > {1'b0, b64d_pkg::TOTAL_MAX}) ? b64d_pkg::TOTAL_MAX : sum[15:0];
  endfunction

  task automatic push_word(input logic [7:0] d, input logic v, input logic l,
                           input logic [15:0] t);
    out_word_t w;
    w.data  = d;
    w.valid = v;
    w.last  = l;
    w.total = l ? t : 16'h0000;
    pending_words.push_back(w);
  endtask

  // Works out the words that one accepted character causes.
  task automatic decode_char(input logic [7:0] c);
    logic [6:0]  s;
    logic [23:0] group;
    s = sextet_of(c);
    if (!s[6]) begin
      if (held_count != 2'd3) begin
        held_sextets = {held_sextets[11:0], s[5:0]};
        held_count   = held_count + 2'd1;
      end else begin
        // Fourth sextet completes the group: three bytes, none of them last.
        group = {held_sextets, s[5:0]};
        push_word(group[23:16], 1'b1, 1'b0, 16'h0);
        push_word(group[15:8],  1'b1, 1'b0, 16'h0);
        push_word(group[7:0],   1'b1, 1'b0, 16'h0);
        msg_bytes    = add_sat(msg_bytes, 3);
        held_sextets = '0;
        held_count   = '0;
      end
    end else begin
      case (held_count)
        2'd2: begin
          msg_bytes = add_sat(msg_bytes, 1);
          push_word(held_sextets[11:4], 1'b1, 1'b1, msg_bytes);
        end
        2'd3: begin
          msg_bytes = add_sat(msg_bytes, 2);
          push_word(held_sextets[17:10], 1'b1, 1'b0, 16'h0);
          push_word(held_sextets[9:2],   1'b1, 1'b1, msg_bytes);
        end
        default: begin
          // Nothing pending, or a lone sextet that is dropped: empty marker.
          push_word(8'h00, 1'b0, 1'b1, msg_bytes);
        end
      endcase
      held_sextets = '0;
      held_count   = '0;
      msg_bytes    = '0;
    end
  endtask

  // Sends one character. Called and returns at a falling edge.
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = c;
    do @(posedge clk); while (!s_tready);
    decode_char(c);
    @(negedge clk);
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) begin
      send_char(txt[i]);
    end
  endtask

  // Holds the sender off until every expected word has arrived.
  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
  endtask

  // Full groups: byte values 0x00 and 0xFF, sextet 63, a NUL end.
  task automatic test_full_groups();
    send_text("TWFu");
    send_text("////");
    send_text("AAAA");
    send_char(CHAR_NUL);
  endtask

  // Each way a message can end, with several kinds of terminator.
  task automatic test_end_cases();
    send_text("TWE=");        // three pending: two bytes flushed
    send_char(CHAR_PAD);      // empty message right after the end
    send_text("TQ=");         // two pending: one byte flushed
    send_char(b64d_pkg::CHAR_UPPER_Z);
    send_char(8'hFF);         // one pending: dropped, empty marker
    send_char(8'h80);
    send_text("z9+");
    send_char(8'h7F);
  endtask

  // Mostly well-formed messages with random content, some raw noise.
  task automatic test_random_messages(input int unsigned item_goal);
    int unsigned sent;
    int unsigned len;
    bit          paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < item_goal) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 6) == 0) begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          send_char(8'($urandom_range(0, 255)));
        end
        sent += len;
      end else begin
        len = $urandom_range(0, 22);
        for (int i = 0; i < len; i++) begin
          send_char(char_of_sextet(6'($urandom_range(0, 63))));
        end
        send_char(pick_terminator());
        sent += len + 1;
      end
      if (!paused && sent >= item_goal / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
    gaps_on = 1'b1;
  endtask

  // One long message of back-to-back full groups; the next message must
  // start again from zero.
  task automatic test_long_message();
    gaps_on = 1'b0;
    for (int i = 0; i < LONG_GROUPS; i++) begin
      send_text("////");
    end
    send_text("///");
    send_char(CHAR_PAD);
    send_text("AAA=");
    gaps_on = 1'b1;
  endtask

  // Receiver: while gaps_on is set, stalls a random number of cycles before each word.
  initial begin : drain_words
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      stall = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // Compares each accepted word with the oldest expected one.
  always @(posedge clk) begin : check_words
    out_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual byte %h user %b last %b",
                 $time, m_tdata[7:0], m_tuser, m_tlast);
        mismatch_count++;
      end else begin
        want = pending_words.pop_front();
        if (m_tdata[7:0] !== want.data) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.data, m_tdata[7:0]);
          mismatch_count++;
        end
        if (m_tuser !== want.valid) begin
          $display("%0t: byte_valid expected %b actual %b", $time, want.valid, m_tuser);
          mismatch_count++;
        end
        if (m_tlast !== want.last) begin
          $display("%0t: msg_last expected %b actual %b", $time, want.last, m_tlast);
          mismatch_count++;
        end
        if (m_tdata[23:8] !== want.total) begin
          $display("%0t: total_bytes expected %0d actual %0d", $time, want.total,
                   m_tdata[23:8]);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: too many cycles in a row without any handshake ends the run.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = 8'h00;
    gaps_on        = 1'b1;
    mismatch_count = 0;
    idle_cycles    = 0;
    held_sextets   = '0;
    held_count     = '0;
    msg_bytes      = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_full_groups();
    test_end_cases();
    test_random_messages(300);
    test_long_message();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
